>>> rtl/core/b64enc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_pkg
// Types, constants and the sextet-to-ASCII mapping shared by the base64
// stream encoder modules.
// ----------------------------------------------------------------------------
package b64enc_pkg;

    localparam int CHAR_W    = 7;
    localparam int SEXTET_W  = 6;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W     = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W   = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_BYTE0 = 2'd0,
        PH_BYTE1 = 2'd1,
        PH_BYTE2 = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] code_char;
        logic              eom;
    } char_entry_t;

    typedef struct packed {
        logic        valid;
        logic        two;
        char_entry_t first;
        char_entry_t second;
    } char_push_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
    } fifo_status_t;

    function automatic logic [CHAR_W-1:0] sextet_to_ascii(input logic [SEXTET_W-1:0] v);
        logic [CHAR_W-1:0] v7;
        logic [CHAR_W-1:0] code;
        v7 = {1'b0, v};
        if (v < 6'd26) begin
            code = 7'd65 + v7;
        end else if (v < 6'd52) begin
            code = 7'd71 + v7;
        end else if (v < 6'd62) begin
            code = v7 - 7'd4;
        end else if (v == 6'd62) begin
            code = 7'd43;
        end else begin
            code = 7'd47;
        end
        return code;
    endfunction

endpackage

>>> rtl/core/b64enc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_core
// Tracks the position inside the three-byte group and the leftover bits,
// and turns each accepted byte into one or two base64 characters.
// ----------------------------------------------------------------------------
module b64enc_core (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    accept,
    input  logic [7:0]              data_byte,
    input  logic                    is_last,
    output b64enc_pkg::char_push_t  push
);
    import b64enc_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [3:0]  leftover_reg;
    logic [3:0]  leftover_next;
    logic [SEXTET_W-1:0] sextet0;
    logic [SEXTET_W-1:0] sextet1;
    logic        two;
    logic        eom1;

    always_comb begin
        sextet0       = data_byte[7:2];
        sextet1       = {data_byte[1:0], 4'b0000};
        two           = 1'b0;
        eom1          = 1'b0;
        phase_next    = PH_BYTE0;
        leftover_next = 4'd0;
        case (phase_reg)
            PH_BYTE1: begin
                sextet0 = {leftover_reg[1:0], data_byte[7:4]};
                sextet1 = {data_byte[3:0], 2'b00};
                if (is_last) begin
                    two  = 1'b1;
                    eom1 = 1'b1;
                end else begin
                    leftover_next = data_byte[3:0];
                    phase_next    = PH_BYTE2;
                end
            end
            PH_BYTE2: begin
                sextet0 = {leftover_reg, data_byte[7:6]};
                sextet1 = data_byte[5:0];
                two     = 1'b1;
                eom1    = is_last;
            end
            default: begin
                if (is_last) begin
                    two  = 1'b1;
                    eom1 = 1'b1;
                end else begin
                    leftover_next = {2'b00, data_byte[1:0]};
                    phase_next    = PH_BYTE1;
                end
            end
        endcase
    end

    always_comb begin
        push.valid            = accept;
        push.two              = two;
        push.first.code_char  = sextet_to_ascii(sextet0);
        push.first.eom        = 1'b0;
        push.second.code_char = sextet_to_ascii(sextet1);
        push.second.eom       = eom1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_BYTE0;
            leftover_reg <= 4'd0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            leftover_reg <= leftover_next;
        end
    end

endmodule

>>> rtl/core/b64enc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64enc_fifo
// Small character queue that takes one or two characters per cycle and
// hands out one character per cycle on the result channel when popped.
// ----------------------------------------------------------------------------
module b64enc_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  b64enc_pkg::char_push_t      push,
    input  logic                        pop,
    output b64enc_pkg::char_entry_t     head,
    output b64enc_pkg::fifo_status_t    status
);
    import b64enc_pkg::*;

    char_entry_t        mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic [LEVEL_W-1:0] push_count;

    always_comb begin
        push_count  = push.valid ? (push.two ? LEVEL_W'(2) : LEVEL_W'(1)) : LEVEL_W'(0);
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        level_next  = level_reg + push_count - LEVEL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            mem[wr_ptr_reg] <= push.first;
            if (push.two) begin
                mem[wr_ptr_reg + PTR_W'(1)] <= push.second;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign status.level = level_reg;

endmodule

>>> rtl/core/base64_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Unpadded base64 encoder for a byte stream with end-of-message marking.
// ----------------------------------------------------------------------------
// The slave channel takes one raw byte per transaction in s_tdata, with
// s_tlast set on the final byte of a message. The master channel gives one
// ASCII character of the standard alphabet per transaction in m_tdata, with
// m_tlast set on the final character of the encoded message.
// The first and second byte of a group each give one character, the third
// gives two, and a final byte that leaves a partial group gives one extra
// character with zero-filled low bits. No padding characters are sent.
// A byte accepted at one clock edge is in the character queue in the next
// cycle; its first character is sent once earlier characters have left.
// The master channel moves one character per cycle while m_tready is high,
// and a long message runs at four characters per three bytes. A four-entry
// character queue sets this: s_tready is high while at least two entries
// are free, so bytes keep flowing while earlier characters wait.
// Reset empties the queue and starts a fresh group. When the receiver
// stalls, the queue fills and s_tready drops until room returns.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] code_char, [7] zero
    output logic       m_tlast
);
    import b64enc_pkg::*;

    char_push_t   push;
    char_entry_t  head;
    fifo_status_t status;
    logic         s_accept;
    logic         m_accept;

    assign s_tready = (status.level <= LEVEL_W'(FIFO_DEPTH - 2));
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (status.level != '0);
    assign m_accept = m_tvalid && m_tready;

    b64enc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (s_accept),
        .data_byte (s_tdata),
        .is_last   (s_tlast),
        .push      (push)
    );

    b64enc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (m_accept),
        .head    (head),
        .status  (status)
    );

    assign m_tdata = {1'b0, head.code_char};
    assign m_tlast = head.eom;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        status.level <= LEVEL_W'(FIFO_DEPTH))
        else $error("Character queue level exceeds its depth.");

    a_accept_gives_char: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid)
        else $error("Accepted byte did not leave a character on the master channel.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (status.level == '0) && !m_tvalid && s_tready)
        else $error("Reset did not empty the character queue.");
`endif

endmodule
